// ===== src/ssd_pkg.sv =====
package ssd_pkg;

  localparam int unsigned DigitsPerScan = 4;
  localparam int unsigned SlotW         = $clog2(DigitsPerScan);
  localparam int unsigned ValueW        = 16;
  localparam int unsigned SegW          = 8;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned SelW          = 4;

  // floor(v / 10) == (v * Recip10) >> Recip10Shift for every v below 2^18
  localparam int unsigned Recip10W     = 17;
  localparam int unsigned Recip10Shift = 19;
  localparam logic [Recip10W-1:0] Recip10 = 17'd52429;

  localparam logic [SlotW-1:0] SlotUnits     = 2'd0;
  localparam logic [SlotW-1:0] SlotTens      = 2'd1;
  localparam logic [SlotW-1:0] SlotHundreds  = 2'd2;
  localparam logic [SlotW-1:0] SlotThousands = 2'd3;

  localparam logic [SelW-1:0] SelUnits     = 4'h7;
  localparam logic [SelW-1:0] SelTens      = 4'hB;
  localparam logic [SelW-1:0] SelHundreds  = 4'hD;
  localparam logic [SelW-1:0] SelThousands = 4'hE;

  typedef struct packed {
    logic [SegW-1:0]   segment_bits;
    logic [SelW-1:0]   digit_select_n;
    logic [DigitW-1:0] digit_value;
    logic              last;
  } result_t;

  function automatic logic [SegW-1:0] seg_font(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0:    s = 8'heb;
      4'd1:    s = 8'h28;
      4'd2:    s = 8'hb3;
      4'd3:    s = 8'hba;
      4'd4:    s = 8'h78;
      4'd5:    s = 8'hda;
      4'd6:    s = 8'hdb;
      4'd7:    s = 8'ha8;
      4'd8:    s = 8'hfb;
      4'd9:    s = 8'hf8;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [SelW-1:0] select_word(input logic [SlotW-1:0] slot);
    logic [SelW-1:0] w;
    unique case (slot)
      SlotUnits:    w = SelUnits;
      SlotTens:     w = SelTens;
      SlotHundreds: w = SelHundreds;
      default:      w = SelThousands;
    endcase
    return w;
  endfunction

endpackage

// ===== src/ssd_digit_unit.sv =====
module ssd_digit_unit (
  input  logic [ssd_pkg::ValueW-1:0] rest_i,
  input  logic [ssd_pkg::SlotW-1:0]  slot_i,
  output logic [ssd_pkg::ValueW-1:0] quot_o,
  output ssd_pkg::result_t           result_o
);

  localparam int unsigned ProdW = ssd_pkg::ValueW + ssd_pkg::Recip10W;

  logic [ProdW-1:0]           prod;
  logic [ssd_pkg::ValueW-1:0] quot_x10;
  logic [ssd_pkg::ValueW-1:0] rem_full;
  logic [ssd_pkg::DigitW-1:0] digit;

  assign prod     = ProdW'(rest_i) * ProdW'(ssd_pkg::Recip10);
  assign quot_o   = ssd_pkg::ValueW'(prod >> ssd_pkg::Recip10Shift);
  assign quot_x10 = (quot_o << 3) + (quot_o << 1);
  assign rem_full = rest_i - quot_x10;
  assign digit    = rem_full[ssd_pkg::DigitW-1:0];

  assign result_o.segment_bits   = ssd_pkg::seg_font(digit);
  assign result_o.digit_select_n = ssd_pkg::select_word(slot_i);
  assign result_o.digit_value    = digit;
  assign result_o.last           = (slot_i == ssd_pkg::SlotThousands);

endmodule

// ===== src/seven_segment_four_digit_scan.sv =====
// Four-digit seven-segment scan driver. Each accepted value yields four
// result transfers in order units, tens, hundreds, thousands; each carries
// the segment font byte, the active-low digit select, the digit itself, and
// last on the thousands result. One digit is peeled off per cycle while the
// output is not stalled, by a constant divide-by-ten unit sitting between
// the value register and the output register, and the next value is taken
// in the same cycle that the thousands digit moves to the output register.
module seven_segment_four_digit_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ssd_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ssd_pkg::SegW-1:0]    segment_bits_o,
  output logic [ssd_pkg::SelW-1:0]    digit_select_n_o,
  output logic [ssd_pkg::DigitW-1:0]  digit_value_o,
  output logic                        last_o
);

  logic [ssd_pkg::ValueW-1:0] rest_q, rest_d;
  logic [ssd_pkg::SlotW-1:0]  slot_q, slot_d;
  logic                       busy_q, busy_d;
  logic                       out_valid_q, out_valid_d;
  ssd_pkg::result_t           res_q, res_d;

  logic [ssd_pkg::ValueW-1:0] quot;
  ssd_pkg::result_t           res_new;
  logic                       out_load;
  logic                       scan_done;
  logic                       in_xfer;

  ssd_digit_unit u_digit (
    .rest_i   (rest_q),
    .slot_i   (slot_q),
    .quot_o   (quot),
    .result_o (res_new)
  );

  assign out_load   = busy_q && (!out_valid_q || out_ready_i);
  assign scan_done  = out_load && (slot_q == ssd_pkg::SlotThousands);
  assign in_ready_o = !busy_q || scan_done;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    rest_d      = rest_q;
    slot_d      = slot_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      res_d       = res_new;
      out_valid_d = 1'b1;
      rest_d      = quot;
      slot_d      = slot_q + 1'b1;
      if (scan_done) begin
        busy_d = 1'b0;
      end
    end
    if (in_xfer) begin
      rest_d = value_i;
      slot_d = ssd_pkg::SlotUnits;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= ssd_pkg::SlotUnits;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    res_q  <= res_d;
  end

  assign out_valid_o      = out_valid_q;
  assign segment_bits_o   = res_q.segment_bits;
  assign digit_select_n_o = res_q.digit_select_n;
  assign digit_value_o    = res_q.digit_value;
  assign last_o           = res_q.last;

  a_last_is_thousands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> digit_select_n_o == ssd_pkg::SelThousands)
    else $error("last flag on a non-thousands result");

  a_digit_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digit_value_o <= 4'd9)
    else $error("digit out of decimal range");

  a_ready_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && in_ready_o |-> slot_q == ssd_pkg::SlotThousands)
    else $error("new value taken mid-scan");

  a_slot_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> slot_q == ssd_pkg::SlotUnits)
    else $error("scan slot left nonzero while idle");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && slot_q != ssd_pkg::SlotThousands |=> busy_q)
    else $error("scan ended early");

endmodule
